/* design/akt_pkg.sv */
package akt_pkg;

	localparam int TABLE_SLOTS_DEF  = 16;
	localparam int KEY_BYTES_DEF    = 8;
	localparam int DIGEST_BYTES_DEF = 8;
	localparam int NAME_CAP_DEF     = 32;

	// Depth of the queue between the front and the back part.
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_LOOKUP   = 2'd1;
	localparam logic [1:0] OP_REMOVE   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [1:0] {
		CLS_REJECT   = 2'd0,
		CLS_REGISTER = 2'd1,
		CLS_LOOKUP   = 2'd2,
		CLS_REMOVE   = 2'd3
	} cls_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] package_key;
		logic [63:0] digest_word;
		logic [31:0] new_version;
		logic [31:0] new_generation;
		logic        reserved_set;
		logic [5:0]  name_length;
	} command_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot_index;
		logic [31:0] found_version;
		logic [31:0] found_generation;
		logic [63:0] found_digest;
	} result_t;

	// Classified transaction as it travels from the front to the back part.
	typedef struct packed {
		cls_t        cls;
		logic [63:0] key;
		logic [63:0] digest;
		logic [31:0] version;
		logic [31:0] generation;
	} entry_t;

	// Record kept in the slot memory.
	typedef struct packed {
		logic [31:0] version;
		logic [31:0] generation;
		logic [63:0] digest;
	} rec_t;

endpackage

/* design/akt_ram.sv */
module akt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/akt_front.sv */
module akt_front #(
	parameter int KEY_BYTES    = 8,
	parameter int DIGEST_BYTES = 8,
	parameter int NAME_CAP     = 32
) (
	input  akt_pkg::command_t command,
	output akt_pkg::entry_t   entry
);
	import akt_pkg::*;

	// Only the low bytes of key and digest take part; a full width mask falls out of the wrap.
	localparam logic [63:0] KEY_MASK = 64'((65'd1 << (8 * KEY_BYTES)) - 65'd1);
	localparam logic [63:0] DIG_MASK = 64'((65'd1 << (8 * DIGEST_BYTES)) - 65'd1);

	logic [63:0] key;
	logic [63:0] dig;
	logic        key_nz;
	logic        rec_ok;

	assign key    = command.package_key & KEY_MASK;
	assign dig    = command.digest_word & DIG_MASK;
	assign key_nz = |key;
	assign rec_ok = key_nz && (|dig) && (|command.new_version) && (|command.new_generation)
		&& !command.reserved_set && (command.name_length != 6'd0)
		&& (32'(command.name_length) < NAME_CAP);

	always_comb begin
		entry.key        = key;
		entry.digest     = dig;
		entry.version    = command.new_version;
		entry.generation = command.new_generation;
		unique case (command.opcode)
			OP_REGISTER: entry.cls = rec_ok ? CLS_REGISTER : CLS_REJECT;
			OP_LOOKUP:   entry.cls = key_nz ? CLS_LOOKUP : CLS_REJECT;
			OP_REMOVE:   entry.cls = key_nz ? CLS_REMOVE : CLS_REJECT;
			default:     entry.cls = CLS_REJECT;
		endcase
	end

endmodule

/* design/akt_queue.sv */
module akt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  akt_pkg::entry_t push_data,
	input  logic            pop,
	output akt_pkg::entry_t head,
	output logic            not_empty,
	output logic            full
);
	import akt_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head      = slots_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* design/akt_back.sv */
module akt_back #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  akt_pkg::entry_t  q_data,
	input  logic             q_valid,
	output logic             q_pop,
	output logic             done,
	output akt_pkg::result_t result
);
	import akt_pkg::*;

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int REC_W  = $bits(rec_t);

	typedef enum logic [3:0] {
		BK_IDLE  = 4'b0001,
		BK_MATCH = 4'b0010,
		BK_PICK  = 4'b0100,
		BK_EXEC  = 4'b1000
	} bk_state_t;

	function automatic logic [SLOT_W-1:0] first_set(input logic [TABLE_SLOTS-1:0] v);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = SLOT_W'(i);
			end
		end
		return idx;
	endfunction

	bk_state_t             state_q;
	entry_t                cur_s1;
	logic [TABLE_SLOTS-1:0] match_s2;
	logic [TABLE_SLOTS-1:0] free_s2;
	logic                  hit_s3;
	logic                  room_s3;
	logic [SLOT_W-1:0]     slot_s3;
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [63:0]           key_q [TABLE_SLOTS];
	logic                  done_q;
	result_t               result_q;

	logic                  rd_en;
	logic [SLOT_W-1:0]     rd_addr;
	logic [REC_W-1:0]      rd_word;
	rec_t                  rd_rec;
	rec_t                  wr_rec;
	logic                  wr_en;
	logic                  set_valid;
	logic                  clr_valid;
	result_t               res;

	akt_ram #(
		.WIDTH(REC_W),
		.DEPTH(TABLE_SLOTS)
	) u_rec_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(slot_s3),
		.wr_data(wr_rec),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_word)
	);

	assign q_pop   = (state_q == BK_IDLE) && q_valid;
	assign rd_en   = (state_q == BK_PICK);
	assign rd_addr = (|match_s2) ? first_set(match_s2) : first_set(free_s2);
	assign rd_rec  = rec_t'(rd_word);
	assign done    = done_q;
	assign result  = result_q;

	// Decision for the transaction in the last step; the record read from the slot is ready here.
	always_comb begin
		wr_rec.version    = cur_s1.version;
		wr_rec.generation = cur_s1.generation;
		wr_rec.digest     = cur_s1.digest;
		wr_en     = 1'b0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		res        = '0;
		res.status = ST_INVALID;
		case (cur_s1.cls)
			CLS_REGISTER: begin
				if (hit_s3) begin
					if (cur_s1.version > rd_rec.version
							&& cur_s1.generation > rd_rec.generation) begin
						wr_en      = 1'b1;
						set_valid  = 1'b1;
						res.status = ST_OK;
					end
				end else if (room_s3) begin
					wr_en      = 1'b1;
					set_valid  = 1'b1;
					res.status = ST_OK;
				end else begin
					res.status = ST_FULL;
				end
			end
			CLS_LOOKUP: begin
				if (hit_s3) begin
					res.status           = ST_OK;
					res.found_version    = rd_rec.version;
					res.found_generation = rd_rec.generation;
					res.found_digest     = rd_rec.digest;
				end else begin
					res.status = ST_NOTFOUND;
				end
			end
			CLS_REMOVE: begin
				if (hit_s3) begin
					res.status = ST_OK;
					clr_valid  = 1'b1;
				end else begin
					res.status = ST_NOTFOUND;
				end
			end
			default: res.status = ST_INVALID;
		endcase
		if (res.status == ST_OK) begin
			res.slot_index = 4'(slot_s3);
		end
		wr_en = wr_en && (state_q == BK_EXEC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == BK_EXEC);
			unique case (state_q)
				BK_IDLE: begin
					if (q_valid) begin
						state_q <= BK_MATCH;
					end
				end
				BK_MATCH: state_q <= BK_PICK;
				BK_PICK:  state_q <= BK_EXEC;
				BK_EXEC: begin
					state_q <= BK_IDLE;
					if (set_valid) begin
						valid_q[slot_s3] <= 1'b1;
					end
					if (clr_valid) begin
						valid_q[slot_s3] <= 1'b0;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_s1 <= q_data;
		end
		if (state_q == BK_MATCH) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				match_s2[i] <= valid_q[i] && (key_q[i] == cur_s1.key);
			end
			free_s2 <= ~valid_q;
		end
		if (state_q == BK_PICK) begin
			hit_s3  <= |match_s2;
			room_s3 <= |free_s2;
			slot_s3 <= rd_addr;
		end
		if (state_q == BK_EXEC) begin
			result_q <= res;
			if (set_valid) begin
				key_q[slot_s3] <= cur_s1.key;
			end
		end
	end

endmodule

/* design/anti_rollback_key_table.sv */
// Channel    Handshake        Payload                    Direction
// command    start / busy     akt_pkg::command_t command  into the block
// result     done (strobe)    akt_pkg::result_t  result   out of the block
//
// A command is taken when start is high and busy is low; busy is high only while
// the two-entry command queue is full. Each command runs through the table engine
// in order (pop, key compare against all slots, slot pick with record read, decide
// and write), and the engine pops the next command only once the last is decided.
// done is registered from the decide step. The receiver cannot stall: done is high
// for one cycle per command. Reset clears the slot valid bits at once, so the table
// is empty with no clearing pass.
module anti_rollback_key_table #(
	parameter int TABLE_SLOTS  = akt_pkg::TABLE_SLOTS_DEF,
	parameter int KEY_BYTES    = akt_pkg::KEY_BYTES_DEF,
	parameter int DIGEST_BYTES = akt_pkg::DIGEST_BYTES_DEF,
	parameter int NAME_CAP     = akt_pkg::NAME_CAP_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  akt_pkg::command_t command,
	output logic              done,
	output akt_pkg::result_t  result
);
	import akt_pkg::*;

	entry_t classified;
	entry_t head;
	logic   not_empty;
	logic   full;
	logic   pop;

	akt_front #(
		.KEY_BYTES   (KEY_BYTES),
		.DIGEST_BYTES(DIGEST_BYTES),
		.NAME_CAP    (NAME_CAP)
	) u_front (
		.command(command),
		.entry  (classified)
	);

	akt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (start && !full),
		.push_data(classified),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty),
		.full     (full)
	);

	akt_back #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_data (head),
		.q_valid(not_empty),
		.q_pop  (pop),
		.done   (done),
		.result (result)
	);

	assign busy = full;

endmodule

/* design/akt_checker.sv */
module akt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              done,
	input akt_pkg::result_t  result
);
	import akt_pkg::*;

	// The engine takes a new command only after the last one is decided, so results never come back to back.
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("results on consecutive cycles");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.slot_index == 4'd0))
		else $error("slot index set on a failed command");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.found_version == 32'd0
			&& result.found_generation == 32'd0 && result.found_digest == 64'd0))
		else $error("record fields set on a failed command");

	// A stored record always has a nonzero version and generation.
	a_found_pair: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.found_version == 32'd0) == (result.found_generation == 32'd0)))
		else $error("stored version and generation disagree on zero");

endmodule

bind anti_rollback_key_table akt_checker u_akt_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.done  (done),
	.result(result)
);
